[design/level_average_peak_hold_core_assert.svh]
// ----------------------------------------------------------------------------
// Level average / peak hold: assertion macros
// Concurrent assertion wrappers, clocked on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef LEVEL_AVERAGE_PEAK_HOLD_CORE_ASSERT_SVH
`define LEVEL_AVERAGE_PEAK_HOLD_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LAPH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("laph assertion failed");
// next-cycle implication
`define LAPH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("laph assertion failed");
`else
`define LAPH_ASSERT_IMP(lbl, ante, cons)
`define LAPH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/laph_pkg.sv]
// ----------------------------------------------------------------------------
// Level average / peak hold: shared package
// Ring sizes, derived widths, mode codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package laph_pkg;

  localparam int DATA_W     = 8;
  localparam int AVG_LEN    = 16;
  localparam int PEAK_LEN   = 32;
  localparam int AVG_IDX_W  = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int PEAK_IDX_W = (PEAK_LEN > 1) ? $clog2(PEAK_LEN) : 1;
  localparam int FILL_W     = $clog2(AVG_LEN + 1);
  localparam int SUM_W      = DATA_W + FILL_W;
  localparam int SCAN_LEN   = (AVG_LEN > PEAK_LEN) ? AVG_LEN : PEAK_LEN;
  localparam int SCAN_W     = $clog2(SCAN_LEN + 1);
  localparam int DIVC_W     = $clog2(SUM_W + 1);
  localparam int MODE_W     = 2;
  localparam int IN_FLD_W   = MODE_W + 3 * DATA_W;
  localparam int IN_W       = ((IN_FLD_W + 7) / 8) * 8;
  localparam int OUT_W      = ((3 * DATA_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LEVEL      = 2'd0,
    MODE_GIVEN_PEAK = 2'd1,
    MODE_ALL_GIVEN  = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic div_load;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/laph_ctrl.sv]
// ----------------------------------------------------------------------------
// Level average / peak hold: controller
// Sequences accept, ring scan, division and result load for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module laph_ctrl
  import laph_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  input  mode_t      in_mode,
  input  dp_sts_t    sts,
  output logic       in_tready,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIVLD, ST_DIV, ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_mode == MODE_LEVEL || in_mode == MODE_GIVEN_PEAK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read word lands in the accumulators here
      ST_DRAIN: begin
        state_nxt = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/laph_dp.sv]
// ----------------------------------------------------------------------------
// Level average / peak hold: datapath
// Rings with valid bits, scan accumulators, restoring divider, held values
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "level_average_peak_hold_core_assert.svh"

module laph_dp
  import laph_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  dp_cmd_t                cmd,
  input  mode_t                  in_mode,
  input  wire logic [DATA_W-1:0] in_level,
  input  wire logic [DATA_W-1:0] in_given_peak,
  input  wire logic [DATA_W-1:0] in_given_average,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [DATA_W-1:0]      out_current,
  output logic [DATA_W-1:0]      out_average,
  output logic [DATA_W-1:0]      out_peak,
  output dp_sts_t                sts
);

  logic [DATA_W-1:0]     avg_mem  [AVG_LEN];
  logic [DATA_W-1:0]     peak_mem [PEAK_LEN];
  logic [AVG_LEN-1:0]    avg_vld_r;
  logic [PEAK_LEN-1:0]   peak_vld_r;

  logic [AVG_IDX_W-1:0]  avg_wr_idx_r;
  logic [PEAK_IDX_W-1:0] peak_wr_idx_r;
  logic [FILL_W-1:0]     fill_r;
  mode_t                 mode_r;
  logic [DATA_W-1:0]     held_cur_r, held_avg_r, held_peak_r;

  logic [SCAN_W-1:0]     scan_cnt_r, rd_idx_r;
  logic                  rd_vld_r;
  logic [DATA_W-1:0]     avg_rd_r, peak_rd_r;
  logic                  avg_rdv_r, peak_rdv_r;
  logic [SUM_W-1:0]      sum_r;
  logic [DATA_W-1:0]     pmax_r;

  logic [FILL_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [DIVC_W-1:0]     div_cnt_r;
  logic [FILL_W:0]       trial;
  logic                  trial_ge;

  logic                  out_tvalid_r;
  logic [DATA_W-1:0]     out_cur_r, out_avg_r, out_peak_r;

  logic                  wr_avg, wr_peak;

  assign wr_avg  = cmd.accept && (in_mode == MODE_LEVEL || in_mode == MODE_GIVEN_PEAK);
  assign wr_peak = cmd.accept && (in_mode == MODE_LEVEL);

  // restoring division step, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[SUM_W-1]};
    trial_ge = (trial >= {1'b0, fill_r});
    if (trial_ge) begin
      rem_nxt = FILL_W'(trial - {1'b0, fill_r});
    end else begin
      rem_nxt = trial[FILL_W-1:0];
    end
    quo_nxt = {quo_r[SUM_W-2:0], trial_ge};
  end

  assign sts.scan_last = (scan_cnt_r == SCAN_W'(SCAN_LEN - 1));
  assign sts.div_last  = (div_cnt_r == DIVC_W'(SUM_W - 1));
  assign sts.out_busy  = out_tvalid_r && !out_tready;

  // ring storage: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_avg) begin
      avg_mem[avg_wr_idx_r] <= in_level;
    end
    if (wr_peak) begin
      peak_mem[peak_wr_idx_r] <= in_level;
    end
    avg_rd_r  <= avg_mem[scan_cnt_r[AVG_IDX_W-1:0]];
    peak_rd_r <= peak_mem[scan_cnt_r[PEAK_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_vld_r     <= '0;
      peak_vld_r    <= '0;
      avg_wr_idx_r  <= '0;
      peak_wr_idx_r <= '0;
      fill_r        <= '0;
      held_cur_r    <= '0;
      held_avg_r    <= '0;
      held_peak_r   <= '0;
      mode_r        <= MODE_LEVEL;
      scan_cnt_r    <= '0;
      rd_vld_r      <= 1'b0;
      div_cnt_r     <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;
      if (cmd.accept) begin
        mode_r     <= in_mode;
        scan_cnt_r <= '0;
        case (in_mode)
          MODE_LEVEL, MODE_GIVEN_PEAK: begin
            held_cur_r <= in_level;
            avg_vld_r[avg_wr_idx_r] <= 1'b1;
            avg_wr_idx_r <= (avg_wr_idx_r == AVG_IDX_W'(AVG_LEN - 1)) ? '0
                                                                      : avg_wr_idx_r + 1'b1;
            if (fill_r != FILL_W'(AVG_LEN)) begin
              fill_r <= fill_r + 1'b1;
            end
            if (in_mode == MODE_LEVEL) begin
              peak_vld_r[peak_wr_idx_r] <= 1'b1;
              peak_wr_idx_r <= (peak_wr_idx_r == PEAK_IDX_W'(PEAK_LEN - 1)) ? '0
                                                                          : peak_wr_idx_r + 1'b1;
            end else begin
              held_peak_r <= in_given_peak;
            end
          end
          MODE_ALL_GIVEN: begin
            held_cur_r  <= in_level;
            held_peak_r <= in_given_peak;
            held_avg_r  <= in_given_average;
          end
          default: begin
            avg_vld_r     <= '0;
            peak_vld_r    <= '0;
            avg_wr_idx_r  <= '0;
            peak_wr_idx_r <= '0;
            fill_r        <= '0;
            held_cur_r    <= '0;
            held_avg_r    <= '0;
            held_peak_r   <= '0;
          end
        endcase
      end
      if (cmd.scan_step) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (cmd.div_load) begin
        div_cnt_r <= '0;
        if (mode_r == MODE_LEVEL) begin
          held_peak_r <= pmax_r;
        end
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (sts.div_last) begin
          held_avg_r <= quo_nxt[DATA_W-1:0];
        end
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload: read tags, accumulators, divider and output data
  always_ff @(posedge clk) begin
    rd_idx_r   <= scan_cnt_r;
    avg_rdv_r  <= avg_vld_r[scan_cnt_r[AVG_IDX_W-1:0]];
    peak_rdv_r <= peak_vld_r[scan_cnt_r[PEAK_IDX_W-1:0]];
    if (cmd.accept) begin
      sum_r  <= '0;
      pmax_r <= '0;
    end else if (rd_vld_r) begin
      if (avg_rdv_r && (rd_idx_r < SCAN_W'(fill_r))) begin
        sum_r <= sum_r + SUM_W'(avg_rd_r);
      end
      if (peak_rdv_r && (rd_idx_r < SCAN_W'(PEAK_LEN)) && (peak_rd_r > pmax_r)) begin
        pmax_r <= peak_rd_r;
      end
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= sum_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.emit) begin
      out_cur_r  <= held_cur_r;
      out_avg_r  <= held_avg_r;
      out_peak_r <= held_peak_r;
    end
  end

  assign out_tvalid  = out_tvalid_r;
  assign out_current = out_cur_r;
  assign out_average = out_avg_r;
  assign out_peak    = out_peak_r;

  `LAPH_ASSERT_IMP(a_fill_sat, 1'b1, fill_r <= FILL_W'(AVG_LEN))
  `LAPH_ASSERT_NXT(a_clear, cmd.accept && in_mode == MODE_CLEAR,
                   fill_r == '0 && avg_vld_r == '0 && held_peak_r == '0)
  `LAPH_ASSERT_IMP(a_emit_free, cmd.emit, !(out_tvalid_r && !out_tready))

endmodule

`default_nettype wire

[design/level_average_peak_hold_core.sv]
// ----------------------------------------------------------------------------
// Level average / peak hold meter core
// Moving average and peak hold over 8-bit meter readings.
// ----------------------------------------------------------------------------
// Usage:
//   One command transfer on in_* gives exactly one result transfer on out_*.
//   Mode 0 pushes the level into the average and peak rings, mode 1 pushes
//   it into the average ring only and takes the peak from the command,
//   mode 2 takes all three values from the command, mode 3 clears rings,
//   pointers and held values.
//   Modes 0 and 1 make one pass of both read ports over the rings, with
//   one scan counter for both, then take one quotient bit a cycle from
//   the restoring divider before the result load. Modes 2 and 3 skip the
//   scan and the division and go straight to the result load.
//   One command is in work at a time; in_tready is high only while idle,
//   so a new command is not taken before the last result is loaded.
//   A stalled output does not stop the next command being taken; it holds
//   the finished result in the output register until out_tready.
//   Reset (rst_n low, synchronous) empties both rings via valid bits and
//   zeros pointers, fill count and held values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module level_average_peak_hold_core
  import laph_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // [1:0] mode, [9:2] level, [17:10] given_peak, [25:18] given_average
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [7:0] current_level, [15:8] average_level, [23:16] peak_level
  output logic [OUT_W-1:0]      out_tdata
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  mode_t               in_mode;
  logic [DATA_W-1:0]   in_level, in_given_peak, in_given_average;
  logic [DATA_W-1:0]   out_current, out_average, out_peak;

  // unpack command fields
  assign in_mode          = mode_t'(in_tdata[MODE_W-1:0]);
  assign in_level         = in_tdata[MODE_W +: DATA_W];
  assign in_given_peak    = in_tdata[MODE_W + DATA_W +: DATA_W];
  assign in_given_average = in_tdata[MODE_W + 2*DATA_W +: DATA_W];

  laph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_mode),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  laph_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_level         (in_level),
    .in_given_peak    (in_given_peak),
    .in_given_average (in_given_average),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_current      (out_current),
    .out_average      (out_average),
    .out_peak         (out_peak),
    .sts              (sts)
  );

  // pack result, zero fill to whole bytes
  assign out_tdata = OUT_W'({out_peak, out_average, out_current});

endmodule

`default_nettype wire

[sim/level_average_peak_hold_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level average / peak hold meter core: self-checking testbench
// Sends a short list of directed commands, then about 450 random ones, to
// the meter. Every command transfer is run through a cycle-free meter
// predictor. Every result transfer is compared field by field with the
// oldest predicted reading. Idling is applied on both stream sides.
// ----------------------------------------------------------------------------

module level_average_peak_hold_core_test;
  import laph_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int RESET_LEN   = 9;
  localparam int RANDOM_LEN  = 150;     // per idling phase, three phases
  localparam int TAIL_CYCLES = 80;      // wait for stray results after the last expected one
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED  = 26;

  // one meter reading, as carried on out_tdata
  typedef struct packed {
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] average;
    logic [DATA_W-1:0] current;
  } reading_t;

  // directed command, with the reading typed in where it is plain
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] given_peak;
    logic [DATA_W-1:0] given_average;
    logic              typed;
    logic [DATA_W-1:0] want_current;
    logic [DATA_W-1:0] want_average;
    logic [DATA_W-1:0] want_peak;
  } meter_row_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int unsigned cycle_count       = 0;
  int unsigned mismatch_count    = 0;
  int unsigned sender_idle_pct   = 27;
  int unsigned receiver_idle_pct = 64;

  reading_t pending_readings [$];

  // predictor state: both rings, their pointers and the held reading
  logic [DATA_W-1:0] avg_hist  [AVG_LEN];
  logic [DATA_W-1:0] peak_hist [PEAK_LEN];
  int unsigned       avg_wr;
  int unsigned       avg_count;
  int unsigned       peak_wr;
  reading_t          held;

  // Rows: first reading after reset, extremes of every field, each mode,
  // a clear then a zero level, then enough level-only commands to
  // saturate the fill count and wrap the average ring.
  meter_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{MODE_LEVEL,      8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{MODE_LEVEL,      8'h00, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h7F, 8'hFF},
    '{MODE_GIVEN_PEAK, 8'hFF, 8'h00, 8'hFF, 1'b1, 8'hFF, 8'hAA, 8'h00},
    '{MODE_GIVEN_PEAK, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_ALL_GIVEN,  8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{MODE_ALL_GIVEN,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
    '{MODE_ALL_GIVEN,  8'hA5, 8'h5A, 8'hC3, 1'b1, 8'hA5, 8'hC3, 8'h5A},
    '{MODE_LEVEL,      8'h01, 8'h3C, 8'h96, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_CLEAR,      8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
    '{MODE_GIVEN_PEAK, 8'h80, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'hFF, 8'h55, 8'hAA, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'hFE, 8'hAA, 8'h55, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'hFD, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h80, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h7F, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h40, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h20, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h10, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h08, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h04, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h02, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'h01, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'hC0, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{MODE_LEVEL,      8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    // fill count saturated; this one overwrites the oldest average entry
    '{MODE_LEVEL,      8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}
  };

  level_average_peak_hold_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Meter predictor
  // --------------------------------------------------------------------------
  function automatic void clear_meter();
    for (int i = 0; i < AVG_LEN; i++) avg_hist[i] = '0;
    for (int i = 0; i < PEAK_LEN; i++) peak_hist[i] = '0;
    avg_wr    = 0;
    avg_count = 0;
    peak_wr   = 0;
    held      = '0;
  endfunction

  // Returns the held reading after one command. Levels go into the average
  // ring in modes 0 and 1 and into the peak ring in mode 0 only. The peak
  // scan covers the whole ring, so cleared zero entries take part.
  function automatic reading_t predict_meter(mode_t mode, logic [DATA_W-1:0] level,
                                             logic [DATA_W-1:0] given_peak,
                                             logic [DATA_W-1:0] given_average);
    int unsigned       total;
    logic [DATA_W-1:0] top;
    total = 0;
    top   = '0;
    case (mode)
      MODE_LEVEL, MODE_GIVEN_PEAK: begin
        held.current     = level;
        avg_hist[avg_wr] = level;
        avg_wr           = (avg_wr + 1) % AVG_LEN;
        if (avg_count < AVG_LEN) avg_count++;
        // ring is written from slot 0 after a clear, so the filled
        // entries are always the lowest ones
        for (int i = 0; i < avg_count; i++) total += avg_hist[i];
        held.average = DATA_W'(total / avg_count);
        if (mode == MODE_LEVEL) begin
          peak_hist[peak_wr] = level;
          peak_wr            = (peak_wr + 1) % PEAK_LEN;
          for (int i = 0; i < PEAK_LEN; i++) begin
            if (peak_hist[i] > top) top = peak_hist[i];
          end
          held.peak = top;
        end else begin
          held.peak = given_peak;
        end
      end
      MODE_ALL_GIVEN: begin
        held.current = level;
        held.peak    = given_peak;
        held.average = given_average;
      end
      default: begin
        clear_meter();
      end
    endcase
    return held;
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Idles at random before raising in_tvalid, then holds the command until
  // the transfer. A back-to-back command keeps in_tvalid high.
  task automatic send_command(input mode_t mode, input logic [DATA_W-1:0] level,
                              input logic [DATA_W-1:0] given_peak,
                              input logic [DATA_W-1:0] given_average,
                              input logic typed, input reading_t typed_reading);
    bit       lowered;
    reading_t predicted;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      if (!lowered) begin
        in_tvalid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    // [1:0] mode, [9:2] level, [17:10] given_peak, [25:18] given_average
    in_tdata  <= IN_W'({given_average, given_peak, level, mode});
    do @(posedge clk); while (!in_tready);
    predicted = predict_meter(mode, level, given_peak, given_average);
    pending_readings.push_back(typed ? typed_reading : predicted);
  endtask

  // Levels lean on the extremes and on small values, where rounding of
  // the mean shows most.
  function automatic logic [DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(0, 15));
      default: return DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly ring-updating commands so the rings fill and wrap; clears are
  // rare so long runs of history build up between them.
  task automatic send_random_command();
    mode_t       mode;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)       mode = MODE_CLEAR;
    else if (pick < 12) mode = MODE_ALL_GIVEN;
    else if (pick < 32) mode = MODE_GIVEN_PEAK;
    else                mode = MODE_LEVEL;
    send_command(mode, pick_level(), DATA_W'($urandom_range(0, 255)),
                 DATA_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = reading_t'(out_tdata[3*DATA_W-1:0]);
        if (pending_readings.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected: %h", got));
        end else begin
          want = pending_readings.pop_front();
          if (got.current !== want.current)
            report_mismatch($sformatf("current_level: expected %0d, got %0d",
                                      want.current, got.current));
          if (got.average !== want.average)
            report_mismatch($sformatf("average_level: expected %0d, got %0d",
                                      want.average, got.average));
          if (got.peak !== want.peak)
            report_mismatch($sformatf("peak_level: expected %0d, got %0d",
                                      want.peak, got.peak));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("level_average_peak_hold_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_meter();
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, under the first idling pattern
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_command(directed_rows[r].mode, directed_rows[r].level,
                   directed_rows[r].given_peak, directed_rows[r].given_average,
                   directed_rows[r].typed,
                   '{peak:    directed_rows[r].want_peak,
                     average: directed_rows[r].want_average,
                     current: directed_rows[r].want_current});
    end

    // random commands: sender-light/receiver-heavy idling, then swapped,
    // then both sides flat out
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 27;
          receiver_idle_pct = 64;
        end
        1: begin
          sender_idle_pct   = 64;
          receiver_idle_pct = 27;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_LEN) send_random_command();
    end
    in_tvalid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    // let any stray result turn up
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("level_average_peak_hold_core: match");
    end else begin
      $display("level_average_peak_hold_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/laph_pkg.sv
design/laph_ctrl.sv
design/laph_dp.sv
design/level_average_peak_hold_core.sv
sim/level_average_peak_hold_core_test.sv
